// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define ASSERT_HOLDS(label, cond)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/rfr_pkg.sv -----
// ----------------------------------------------------------------------------
// rfr_pkg
// types, constants and the hex digit decoder of the frame repeat filter
// ----------------------------------------------------------------------------
package rfr_pkg;

  localparam int FRAME_DEPTH   = 16;
  localparam int POS_W         = $clog2(FRAME_DEPTH + 1);
  localparam int IDX_W         = $clog2(FRAME_DEPTH);
  localparam int ID_FIRST      = 3;
  localparam int ID_END        = 11;
  localparam int ID_DIGITS     = ID_END - ID_FIRST;
  localparam int NIBBLE_BITS   = 4;
  localparam int DIG_W         = $clog2(ID_DIGITS + 1);
  localparam logic [31:0] HOLDOFF_RESET = 32'd150;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [31:0] tick_time;
  } in_t;

  typedef struct packed {
    logic [31:0] tag_id;
    logic        accepted;
    logic        frame_changed;
  } out_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
      end
      return d[3:0];
    end
  endfunction

endpackage

// ----- rtl/rfid_frame_repeat_filter_core.sv -----
// the result of a last byte is registered into out_data, or into the skid entry while the output stalls
// throughput: one byte request per cycle while in_stall is low, set by the combinational compare/update path
// a two-entry output register and skid buffer keep input flowing while a result waits
// in_stall rises only when the skid entry is full
// rst is synchronous: control state clears, hold-off returns to 150 ticks
// ----------------------------------------------------------------------------
// rfid_frame_repeat_filter_core
// compares each tag-reader frame with the previous one, decodes the hex tag
// id and flags new frames or repeats past the hold-off time
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfid_frame_repeat_filter_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rfr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rfr_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_data
);

  logic [7:0]               store [rfr_pkg::FRAME_DEPTH];
  logic [rfr_pkg::POS_W-1:0] prior_length;
  logic [rfr_pkg::POS_W-1:0] prior_nonzero_end;
  logic [rfr_pkg::POS_W-1:0] byte_position;
  logic [rfr_pkg::POS_W-1:0] running_nonzero_end;
  logic                      all_matched;
  logic [31:0]               id_accumulator;
  logic [31:0]               last_frame_time;
  logic [31:0]               holdoff_ticks;

  logic                      skid_valid;
  rfr_pkg::out_t             skid_data;

  logic                      in_take;
  logic                      out_take;
  logic                      in_range;
  logic                      in_id;
  logic [7:0]                prev_byte;
  logic                      all_matched_next;
  logic [rfr_pkg::POS_W-1:0] running_nonzero_end_next;
  logic [31:0]               id_accumulator_next;
  logic [rfr_pkg::POS_W-1:0] byte_position_next;
  logic [rfr_pkg::DIG_W-1:0] digits;
  logic [2:0]                nib_shift;
  logic [31:0]               tag;
  logic [31:0]               diff;
  logic                      changed;
  rfr_pkg::out_t             result;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  always_comb begin
    in_range = byte_position < rfr_pkg::POS_W'(rfr_pkg::FRAME_DEPTH);
    in_id    = in_range &&
               byte_position >= rfr_pkg::POS_W'(rfr_pkg::ID_FIRST) &&
               byte_position <  rfr_pkg::POS_W'(rfr_pkg::ID_END);
    prev_byte = 8'h00;
    if (byte_position < prior_length) begin
      prev_byte = store[byte_position[rfr_pkg::IDX_W-1:0]];
    end
    all_matched_next         = all_matched && (!in_range || in_data.frame_byte == prev_byte);
    running_nonzero_end_next = running_nonzero_end;
    byte_position_next       = byte_position;
    id_accumulator_next      = id_accumulator;
    if (in_range) begin
      byte_position_next = byte_position + 1'b1;
      if (in_data.frame_byte != 8'h00) begin
        running_nonzero_end_next = byte_position + 1'b1;
      end
    end
    if (in_id) begin
      id_accumulator_next = {id_accumulator[31-rfr_pkg::NIBBLE_BITS:0],
                             rfr_pkg::hex_digit(in_data.frame_byte)};
    end
    // byte_position_next is the frame length, capped at FRAME_DEPTH, on a last byte
    if (byte_position_next <= rfr_pkg::POS_W'(rfr_pkg::ID_FIRST)) begin
      digits = '0;
    end else if (byte_position_next >= rfr_pkg::POS_W'(rfr_pkg::ID_END)) begin
      digits = rfr_pkg::DIG_W'(rfr_pkg::ID_DIGITS);
    end else begin
      digits = rfr_pkg::DIG_W'(byte_position_next - rfr_pkg::POS_W'(rfr_pkg::ID_FIRST));
    end
    nib_shift = 3'(rfr_pkg::DIG_W'(rfr_pkg::ID_DIGITS) - digits);
    if (digits == '0) begin
      tag = 32'h0;
    end else begin
      tag = id_accumulator_next << {nib_shift, 2'b00};
    end
    changed = !(all_matched_next && prior_nonzero_end <= byte_position_next);
    diff    = in_data.tick_time - last_frame_time;
    result.tag_id        = tag;
    result.frame_changed = changed;
    result.accepted      = changed || (diff > holdoff_ticks);
  end

  always_ff @(posedge clk) begin
    if (in_take && in_range) begin
      store[byte_position[rfr_pkg::IDX_W-1:0]] <= in_data.frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_length        <= '0;
      prior_nonzero_end   <= '0;
      byte_position       <= '0;
      running_nonzero_end <= '0;
      all_matched         <= 1'b1;
      id_accumulator      <= '0;
      last_frame_time     <= '0;
      holdoff_ticks       <= rfr_pkg::HOLDOFF_RESET;
    end else begin
      if (cfg_we) begin
        holdoff_ticks <= cfg_data;
      end
      if (in_take) begin
        if (in_data.last_byte) begin
          prior_length        <= byte_position_next;
          prior_nonzero_end   <= running_nonzero_end_next;
          last_frame_time     <= in_data.tick_time;
          byte_position       <= '0;
          running_nonzero_end <= '0;
          all_matched         <= 1'b1;
          id_accumulator      <= '0;
        end else begin
          byte_position       <= byte_position_next;
          running_nonzero_end <= running_nonzero_end_next;
          all_matched         <= all_matched_next;
          id_accumulator      <= id_accumulator_next;
        end
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (in_take && in_data.last_byte) begin
      if (!out_valid || out_take) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_HOLDS(a_skid_behind_out, !skid_valid || out_valid)
  `ASSERT_NEXT(a_skid_fill, out_valid && out_stall && in_take && in_data.last_byte, skid_valid)
  `ASSERT_NEXT(a_frame_restart, in_take && in_data.last_byte, byte_position == '0 && all_matched)
  `ASSERT_HOLDS(a_changed_accepted, !(out_valid && out_data.frame_changed) || out_data.accepted)

endmodule
